/* rtl/ogbe_pkg.sv */
// Shared types, codes and helpers for the OneMax breeding engine.
package ogbe_pkg;

  localparam int unsigned GENES_DEF = 64;
  localparam int unsigned POP_DEF   = 64;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned SCORE_W = 7;
  localparam int unsigned THR_W   = 17;
  localparam int unsigned CFG_W   = 17;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BREED = 2'd1;
  localparam logic [1:0] CMD_BEST  = 2'd2;

  localparam logic [1:0] CFG_POP_IN_USE = 2'd0;
  localparam logic [1:0] CFG_XOVER_THR  = 2'd1;
  localparam logic [1:0] CFG_MUT_THR    = 2'd2;

  localparam logic [SCORE_W-1:0] POP_IN_USE_RST = 7'd50;
  localparam logic [THR_W-1:0]   XOVER_THR_RST  = 17'd45875;
  localparam logic [THR_W-1:0]   MUT_THR_RST    = 17'd13107;

  localparam logic [2:0] ST_LOADED     = 3'd0;
  localparam logic [2:0] ST_REPLACED   = 3'd1;
  localparam logic [2:0] ST_NOT_BETTER = 3'd2;
  localparam logic [2:0] ST_NO_XOVER   = 3'd3;
  localparam logic [2:0] ST_BAD_PARENT = 3'd4;
  localparam logic [2:0] ST_BEST       = 3'd5;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_IN,
    RD_MOM,
    RD_SCAN,
    RD_BEST
  } rd_src_e;

  typedef enum logic [2:0] {
    OK_LOAD,
    OK_BREED,
    OK_NO_XOVER,
    OK_BAD_PARENT,
    OK_BEST
  } out_kind_e;

  typedef struct packed {
    logic      latch;
    rd_src_e   rd_src;
    logic      mix;
    logic      wr_load;
    logic      wr_child;
    logic      scan_start;
    logic      out_load;
    out_kind_e out_kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [1:0] cmd;
    logic       xover_ok;
    logic       parents_ok;
    logic       scan_done;
  } dp_stat_t;

  function automatic logic [SCORE_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x1;
    logic [WORD_W-1:0] x2;
    logic [WORD_W-1:0] x3;
    logic [WORD_W-1:0] x4;
    logic [WORD_W-1:0] x5;
    logic [WORD_W-1:0] x6;
    x1 = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    x2 = (x1 & 64'h3333_3333_3333_3333) + ((x1 >> 2) & 64'h3333_3333_3333_3333);
    x3 = (x2 + (x2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    x4 = x3 + (x3 >> 8);
    x5 = x4 + (x4 >> 16);
    x6 = x5 + (x5 >> 32);
    return x6[SCORE_W-1:0];
  endfunction

endpackage

/* rtl/ogbe_ctrl.sv */
// Sequencing controller of the OneMax breeding engine.
module ogbe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ogbe_pkg::dp_stat_t st_i,
  output ogbe_pkg::ctl_cmd_t ctl_o
);

  typedef enum logic [3:0] {
    IDLE,
    LOAD,
    BR_MOM,
    BR_MIX,
    BR_EVAL,
    REJECT,
    SCAN,
    SC_FETCH,
    SC_OUT
  } state_e;

  state_e              state_q, state_d;
  ogbe_pkg::out_kind_e reject_q, reject_d;

  assign in_stall_o = (state_q != IDLE);

  always_comb begin
    state_d          = state_q;
    reject_d         = reject_q;
    ctl_o            = '0;
    ctl_o.rd_src     = ogbe_pkg::RD_NONE;
    ctl_o.out_kind   = ogbe_pkg::OK_LOAD;
    unique case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch  = 1'b1;
          ctl_o.rd_src = ogbe_pkg::RD_IN;
          unique case (st_i.cmd)
            ogbe_pkg::CMD_LOAD: state_d = LOAD;
            ogbe_pkg::CMD_BREED: begin
              if (!st_i.xover_ok) begin
                reject_d = ogbe_pkg::OK_NO_XOVER;
                state_d  = REJECT;
              end else if (!st_i.parents_ok) begin
                reject_d = ogbe_pkg::OK_BAD_PARENT;
                state_d  = REJECT;
              end else begin
                state_d = BR_MOM;
              end
            end
            ogbe_pkg::CMD_BEST: begin
              ctl_o.scan_start = 1'b1;
              state_d          = SCAN;
            end
            default: state_d = IDLE;
          endcase
        end
      end
      LOAD: begin
        if (st_i.out_free) begin
          ctl_o.wr_load  = 1'b1;
          ctl_o.out_load = 1'b1;
          ctl_o.out_kind = ogbe_pkg::OK_LOAD;
          state_d        = IDLE;
        end
      end
      BR_MOM: begin
        ctl_o.rd_src = ogbe_pkg::RD_MOM;
        state_d      = BR_MIX;
      end
      BR_MIX: begin
        ctl_o.mix = 1'b1;
        state_d   = BR_EVAL;
      end
      BR_EVAL: begin
        if (st_i.out_free) begin
          ctl_o.wr_child = 1'b1;
          ctl_o.out_load = 1'b1;
          ctl_o.out_kind = ogbe_pkg::OK_BREED;
          state_d        = IDLE;
        end
      end
      REJECT: begin
        if (st_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_kind = reject_q;
          state_d        = IDLE;
        end
      end
      SCAN: begin
        ctl_o.rd_src = ogbe_pkg::RD_SCAN;
        if (st_i.scan_done) begin
          state_d = SC_FETCH;
        end
      end
      SC_FETCH: begin
        ctl_o.rd_src = ogbe_pkg::RD_BEST;
        state_d      = SC_OUT;
      end
      SC_OUT: begin
        if (st_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_kind = ogbe_pkg::OK_BEST;
          state_d        = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      reject_q <= ogbe_pkg::OK_NO_XOVER;
    end else begin
      state_q  <= state_d;
      reject_q <= reject_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.wr_load || ctl_o.wr_child) |-> ctl_o.out_load)
    else $error("population write without a result word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BR_MOM) |-> ($past(state_q) == IDLE && $past(st_i.parents_ok)))
    else $error("breeding started with bad parents");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SC_FETCH) |=> (state_q == SC_OUT))
    else $error("best fetch not followed by best report");

endmodule

/* rtl/ogbe_dp.sv */
// Datapath of the OneMax breeding engine: population store, breeding and best scan.
module ogbe_dp #(
  parameter int unsigned GENES = ogbe_pkg::GENES_DEF,
  parameter int unsigned POP   = ogbe_pkg::POP_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ogbe_pkg::ctl_cmd_t                  ctl_i,
  output ogbe_pkg::dp_stat_t                  st_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [ogbe_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic [1:0]                          cmd_i,
  input  logic [ogbe_pkg::IDX_W-1:0]          target_index_i,
  input  logic [ogbe_pkg::IDX_W-1:0]          mother_index_i,
  input  logic [ogbe_pkg::WORD_W-1:0]         gene_bits_i,
  input  logic [15:0]                         chance_i,
  input  logic [ogbe_pkg::IDX_W-1:0]          cut_point_i,
  input  logic [ogbe_pkg::IDX_W-1:0]          flip_position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic [ogbe_pkg::WORD_W-1:0]         child_genes_o,
  output logic [ogbe_pkg::SCORE_W-1:0]        child_score_o,
  output logic [ogbe_pkg::IDX_W-1:0]          best_index_o,
  output logic [ogbe_pkg::SCORE_W-1:0]        best_score_o,
  output logic [ogbe_pkg::WORD_W-1:0]         best_genes_o,
  output logic                                optimum_found_o
);

  localparam int unsigned AW   = (POP > 1) ? $clog2(POP) : 1;
  localparam int unsigned NMAX = (POP < 64) ? POP : 64;
  localparam logic [ogbe_pkg::WORD_W-1:0] GMASK = {ogbe_pkg::WORD_W{1'b1}} >> (64 - GENES);

  logic [ogbe_pkg::WORD_W-1:0]  pop_mem [POP];
  logic [ogbe_pkg::SCORE_W-1:0] score_mem [POP];

  logic [ogbe_pkg::SCORE_W-1:0] piu_q;
  logic [ogbe_pkg::THR_W-1:0]   xthr_q;
  logic [ogbe_pkg::THR_W-1:0]   mthr_q;

  logic [ogbe_pkg::IDX_W-1:0]   tgt_q;
  logic [ogbe_pkg::IDX_W-1:0]   mom_q;
  logic [ogbe_pkg::WORD_W-1:0]  genes_q;
  logic                         mut_q;
  logic [ogbe_pkg::IDX_W-1:0]   cut_q;
  logic [ogbe_pkg::IDX_W-1:0]   flip_q;

  logic [ogbe_pkg::WORD_W-1:0]  pop_rdata_q;
  logic [ogbe_pkg::SCORE_W-1:0] score_rdata_q;
  logic [ogbe_pkg::WORD_W-1:0]  father_q;
  logic [ogbe_pkg::WORD_W-1:0]  child_q;

  logic [ogbe_pkg::SCORE_W-1:0] scan_cnt_q;
  logic [ogbe_pkg::SCORE_W-1:0] rd_idx_q;
  logic                         rd_v_q;
  logic [ogbe_pkg::IDX_W-1:0]   best_idx_q;
  logic [ogbe_pkg::SCORE_W-1:0] best_score_q;

  logic                         out_valid_q;
  logic [2:0]                   status_q;
  logic [ogbe_pkg::WORD_W-1:0]  child_genes_q;
  logic [ogbe_pkg::SCORE_W-1:0] child_score_q;
  logic [ogbe_pkg::IDX_W-1:0]   best_index_q;
  logic [ogbe_pkg::SCORE_W-1:0] best_score_out_q;
  logic [ogbe_pkg::WORD_W-1:0]  best_genes_q;
  logic                         optimum_q;

  logic [ogbe_pkg::SCORE_W-1:0] n_eff;
  logic [ogbe_pkg::SCORE_W-1:0] lim;
  logic                         scan_issue;
  logic [ogbe_pkg::IDX_W-1:0]   cut_clamp;
  logic [ogbe_pkg::IDX_W-1:0]   flip_red;
  int                           fr;
  logic [ogbe_pkg::WORD_W-1:0]  take;
  logic [ogbe_pkg::WORD_W-1:0]  child_mix;
  logic [ogbe_pkg::SCORE_W-1:0] child_cnt;
  logic [ogbe_pkg::SCORE_W-1:0] load_cnt;
  logic                         better;
  logic                         tgt_in_store;
  logic                         pop_re;
  logic                         score_re;
  logic [AW-1:0]                pop_raddr;
  logic [AW-1:0]                score_raddr;
  logic                         mem_we;
  logic [AW-1:0]                waddr;
  logic [ogbe_pkg::WORD_W-1:0]  pop_wdata;
  logic [ogbe_pkg::SCORE_W-1:0] score_wdata;

  // effective population and scan length
  assign n_eff = (int'(piu_q) > NMAX) ? ogbe_pkg::SCORE_W'(NMAX) : piu_q;
  assign lim   = (n_eff == '0) ? ogbe_pkg::SCORE_W'(1) : n_eff;

  assign st_o.out_free   = !out_valid_q || !out_stall_i;
  assign st_o.cmd        = cmd_i;
  assign st_o.xover_ok   = ({1'b0, chance_i} < xthr_q);
  assign st_o.parents_ok = ({1'b0, target_index_i} < n_eff) &&
                           ({1'b0, mother_index_i} < n_eff) &&
                           (target_index_i != mother_index_i);
  assign st_o.scan_done  = (scan_cnt_q >= lim) && !rd_v_q;

  assign cut_clamp = (int'(cut_point_i) > int'(GENES) - 1) ?
                     ogbe_pkg::IDX_W'(GENES - 1) : cut_point_i;

  // flip position modulo GENES by restoring subtraction
  always_comb begin
    fr = int'(flip_position_i);
    for (int k = 5; k >= 0; k--) begin
      if (fr >= int'(GENES << k)) begin
        fr = fr - int'(GENES << k);
      end
    end
    flip_red = ogbe_pkg::IDX_W'(fr);
  end

  assign take      = {ogbe_pkg::WORD_W{1'b1}} >> (6'd63 - cut_q);
  assign child_mix = (((father_q & take) | (pop_rdata_q & ~take)) & GMASK) ^
                     (mut_q ? (ogbe_pkg::WORD_W'(1) << flip_q) : '0);
  assign child_cnt = ogbe_pkg::popcount64(child_q);
  assign load_cnt  = ogbe_pkg::popcount64(genes_q & GMASK);
  assign better    = child_cnt > score_rdata_q;
  assign tgt_in_store = (int'(tgt_q) < int'(POP));

  assign scan_issue = (ctl_i.rd_src == ogbe_pkg::RD_SCAN) && (scan_cnt_q < lim);

  always_comb begin
    pop_re      = 1'b0;
    score_re    = 1'b0;
    pop_raddr   = AW'(target_index_i);
    score_raddr = AW'(target_index_i);
    unique case (ctl_i.rd_src)
      ogbe_pkg::RD_NONE: ;
      ogbe_pkg::RD_IN: begin
        pop_re   = 1'b1;
        score_re = 1'b1;
      end
      ogbe_pkg::RD_MOM: begin
        pop_re    = 1'b1;
        pop_raddr = AW'(mom_q);
      end
      ogbe_pkg::RD_SCAN: begin
        score_re    = scan_issue;
        score_raddr = AW'(scan_cnt_q);
      end
      ogbe_pkg::RD_BEST: begin
        pop_re    = 1'b1;
        pop_raddr = AW'(best_idx_q);
      end
      default: ;
    endcase
  end

  assign mem_we      = (ctl_i.wr_load && tgt_in_store) || (ctl_i.wr_child && better);
  assign waddr       = AW'(tgt_q);
  assign pop_wdata   = ctl_i.wr_load ? (genes_q & GMASK) : child_q;
  assign score_wdata = ctl_i.wr_load ? load_cnt : child_cnt;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pop_mem[waddr]   <= pop_wdata;
      score_mem[waddr] <= score_wdata;
    end
    if (pop_re) begin
      pop_rdata_q <= pop_mem[pop_raddr];
    end
    if (score_re) begin
      score_rdata_q <= score_mem[score_raddr];
    end
  end

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q       <= ogbe_pkg::POP_IN_USE_RST;
      xthr_q      <= ogbe_pkg::XOVER_THR_RST;
      mthr_q      <= ogbe_pkg::MUT_THR_RST;
      scan_cnt_q  <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ogbe_pkg::CFG_POP_IN_USE: piu_q  <= cfg_data_i[ogbe_pkg::SCORE_W-1:0];
          ogbe_pkg::CFG_XOVER_THR:  xthr_q <= cfg_data_i[ogbe_pkg::THR_W-1:0];
          ogbe_pkg::CFG_MUT_THR:    mthr_q <= cfg_data_i[ogbe_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.scan_start) begin
        scan_cnt_q <= '0;
      end else if (scan_issue) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      rd_v_q      <= scan_issue && !ctl_i.scan_start;
      out_valid_q <= ctl_i.out_load || (out_valid_q && out_stall_i);
    end
  end

  // item, breeding and scan payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      tgt_q   <= target_index_i;
      mom_q   <= mother_index_i;
      genes_q <= gene_bits_i;
      mut_q   <= ({1'b0, chance_i} < mthr_q);
      cut_q   <= cut_clamp;
      flip_q  <= flip_red;
    end
    if (ctl_i.rd_src == ogbe_pkg::RD_MOM) begin
      father_q <= pop_rdata_q;
    end
    if (ctl_i.mix) begin
      child_q <= child_mix;
    end
    if (scan_issue) begin
      rd_idx_q <= scan_cnt_q;
    end
    if (rd_v_q && ((rd_idx_q == '0) || (score_rdata_q > best_score_q))) begin
      best_idx_q   <= ogbe_pkg::IDX_W'(rd_idx_q);
      best_score_q <= score_rdata_q;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_q         <= ogbe_pkg::ST_LOADED;
      child_genes_q    <= '0;
      child_score_q    <= '0;
      best_index_q     <= '0;
      best_score_out_q <= '0;
      best_genes_q     <= '0;
      optimum_q        <= 1'b0;
      unique case (ctl_i.out_kind)
        ogbe_pkg::OK_LOAD: status_q <= ogbe_pkg::ST_LOADED;
        ogbe_pkg::OK_BREED: begin
          status_q      <= better ? ogbe_pkg::ST_REPLACED : ogbe_pkg::ST_NOT_BETTER;
          child_genes_q <= child_q;
          child_score_q <= child_cnt;
        end
        ogbe_pkg::OK_NO_XOVER:   status_q <= ogbe_pkg::ST_NO_XOVER;
        ogbe_pkg::OK_BAD_PARENT: status_q <= ogbe_pkg::ST_BAD_PARENT;
        ogbe_pkg::OK_BEST: begin
          status_q         <= ogbe_pkg::ST_BEST;
          best_index_q     <= best_idx_q;
          best_score_out_q <= best_score_q;
          best_genes_q     <= pop_rdata_q;
          optimum_q        <= (best_score_q == ogbe_pkg::SCORE_W'(GENES));
        end
        default: status_q <= ogbe_pkg::ST_LOADED;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign child_genes_o   = child_genes_q;
  assign child_score_o   = child_score_q;
  assign best_index_o    = best_index_q;
  assign best_score_o    = best_score_out_q;
  assign best_genes_o    = best_genes_q;
  assign optimum_found_o = optimum_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> st_o.out_free)
    else $error("result word overwritten before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (rd_idx_q < lim))
    else $error("score scan beyond population in use");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ogbe_pkg::ST_REPLACED ||
                     status_q == ogbe_pkg::ST_NOT_BETTER))
    |-> (child_score_q == ogbe_pkg::popcount64(child_genes_q)))
    else $error("child score does not match child genes");

endmodule

/* rtl/onemax_genetic_breeding_engine.sv */
// Top level of the OneMax genetic breeding engine.
// One command word is handled at a time; every command but the unused code 3
// returns one result word. A breed that the chance test or the parent check
// rejects goes straight to its result word. Breeding uses the single read port
// of the population memory, which fetches father and mother one after the
// other; the best query walks the score memory one entry per cycle over the
// population in use (at least one entry). A new command is taken as soon as
// the previous one has reached the output register. The population and score
// memories hold undefined data until loaded.
module onemax_genetic_breeding_engine #(
  parameter int unsigned GENES = ogbe_pkg::GENES_DEF,
  parameter int unsigned POP   = ogbe_pkg::POP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ogbe_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic [ogbe_pkg::IDX_W-1:0]   target_index_i,
  input  logic [ogbe_pkg::IDX_W-1:0]   mother_index_i,
  input  logic [ogbe_pkg::WORD_W-1:0]  gene_bits_i,
  input  logic [15:0]                  chance_i,
  input  logic [ogbe_pkg::IDX_W-1:0]   cut_point_i,
  input  logic [ogbe_pkg::IDX_W-1:0]   flip_position_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [ogbe_pkg::WORD_W-1:0]  child_genes_o,
  output logic [ogbe_pkg::SCORE_W-1:0] child_score_o,
  output logic [ogbe_pkg::IDX_W-1:0]   best_index_o,
  output logic [ogbe_pkg::SCORE_W-1:0] best_score_o,
  output logic [ogbe_pkg::WORD_W-1:0]  best_genes_o,
  output logic                         optimum_found_o
);

  ogbe_pkg::ctl_cmd_t ctl;
  ogbe_pkg::dp_stat_t st;

  ogbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  ogbe_dp #(
    .GENES (GENES),
    .POP   (POP)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .st_o            (st),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd_i),
    .target_index_i  (target_index_i),
    .mother_index_i  (mother_index_i),
    .gene_bits_i     (gene_bits_i),
    .chance_i        (chance_i),
    .cut_point_i     (cut_point_i),
    .flip_position_i (flip_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .child_genes_o   (child_genes_o),
    .child_score_o   (child_score_o),
    .best_index_o    (best_index_o),
    .best_score_o    (best_score_o),
    .best_genes_o    (best_genes_o),
    .optimum_found_o (optimum_found_o)
  );

endmodule

/* test/tb.sv */
// Self-checking testbench for the OneMax breeding engine: directed table, then random phases.
module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES = 9;
  localparam int PHASE_WORDS = 196;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic [ogbe_pkg::IDX_W-1:0]   target_index;
    logic [ogbe_pkg::IDX_W-1:0]   mother_index;
    logic [ogbe_pkg::WORD_W-1:0]  gene_bits;
    logic [15:0]                  chance;
    logic [ogbe_pkg::IDX_W-1:0]   cut_point;
    logic [ogbe_pkg::IDX_W-1:0]   flip_position;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]                   status;
    logic [ogbe_pkg::WORD_W-1:0]  child_genes;
    logic [ogbe_pkg::SCORE_W-1:0] child_score;
    logic [ogbe_pkg::IDX_W-1:0]   best_index;
    logic [ogbe_pkg::SCORE_W-1:0] best_score;
    logic [ogbe_pkg::WORD_W-1:0]  best_genes;
    logic                         optimum_found;
  } result_word_t;

  typedef struct packed {
    cmd_word_t    w;
    logic         typed;
    result_word_t want;
  } dir_row_t;

  localparam result_word_t NO_RESULT = '0;
  localparam logic [ogbe_pkg::WORD_W-1:0] ALL_ONES = {ogbe_pkg::WORD_W{1'b1}};

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [1:0]                    cfg_idx_i = ogbe_pkg::CFG_POP_IN_USE;
  logic [ogbe_pkg::CFG_W-1:0]    cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    cmd_i = ogbe_pkg::CMD_LOAD;
  logic [ogbe_pkg::IDX_W-1:0]    target_index_i = '0;
  logic [ogbe_pkg::IDX_W-1:0]    mother_index_i = '0;
  logic [ogbe_pkg::WORD_W-1:0]   gene_bits_i = '0;
  logic [15:0]                   chance_i = '0;
  logic [ogbe_pkg::IDX_W-1:0]    cut_point_i = '0;
  logic [ogbe_pkg::IDX_W-1:0]    flip_position_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [2:0]                    status_o;
  logic [ogbe_pkg::WORD_W-1:0]   child_genes_o;
  logic [ogbe_pkg::SCORE_W-1:0]  child_score_o;
  logic [ogbe_pkg::IDX_W-1:0]    best_index_o;
  logic [ogbe_pkg::SCORE_W-1:0]  best_score_o;
  logic [ogbe_pkg::WORD_W-1:0]   best_genes_o;
  logic                          optimum_found_o;

  logic [ogbe_pkg::WORD_W-1:0]   store_genes [64];
  logic [ogbe_pkg::SCORE_W-1:0]  store_score [64];
  logic [6:0]                    reg_pop = ogbe_pkg::POP_IN_USE_RST;
  logic [ogbe_pkg::THR_W-1:0]    reg_xover = ogbe_pkg::XOVER_THR_RST;
  logic [ogbe_pkg::THR_W-1:0]    reg_mut = ogbe_pkg::MUT_THR_RST;

  result_word_t         pending_results [$];
  dir_row_t             directed_rows [$];
  result_word_t         out_seen;
  int                   mismatch_count = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;

  int unsigned set_pop [PHASES] = '{64, 2, 64, 1, 0, 127, 0, 0, 50};
  int unsigned set_xover [PHASES] = '{65536, 65536, 0, 65536, 50000, 131071, 0, 0, 45875};
  int unsigned set_mut [PHASES] = '{0, 65536, 0, 32768, 20000, 13107, 0, 0, 13107};

  onemax_genetic_breeding_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .target_index_i  (target_index_i),
    .mother_index_i  (mother_index_i),
    .gene_bits_i     (gene_bits_i),
    .chance_i        (chance_i),
    .cut_point_i     (cut_point_i),
    .flip_position_i (flip_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .child_genes_o   (child_genes_o),
    .child_score_o   (child_score_o),
    .best_index_o    (best_index_o),
    .best_score_o    (best_score_o),
    .best_genes_o    (best_genes_o),
    .optimum_found_o (optimum_found_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic cmd_word_t cmd_of(input logic [1:0] c, input int t, input int m,
                                       input logic [ogbe_pkg::WORD_W-1:0] g,
                                       input int ch, input int cu, input int fl);
    cmd_word_t w;
    w.cmd = c;
    w.target_index = ogbe_pkg::IDX_W'(t);
    w.mother_index = ogbe_pkg::IDX_W'(m);
    w.gene_bits = g;
    w.chance = 16'(ch);
    w.cut_point = ogbe_pkg::IDX_W'(cu);
    w.flip_position = ogbe_pkg::IDX_W'(fl);
    return w;
  endfunction

  function automatic result_word_t result_of(input logic [2:0] st,
                                             input logic [ogbe_pkg::WORD_W-1:0] cg,
                                             input int cs, input int bi, input int bs,
                                             input logic [ogbe_pkg::WORD_W-1:0] bg,
                                             input logic opt);
    result_word_t r;
    r.status = st;
    r.child_genes = cg;
    r.child_score = ogbe_pkg::SCORE_W'(cs);
    r.best_index = ogbe_pkg::IDX_W'(bi);
    r.best_score = ogbe_pkg::SCORE_W'(bs);
    r.best_genes = bg;
    r.optimum_found = opt;
    return r;
  endfunction

  // Mirrors the engine: updates the local store and returns the word it owes.
  function automatic result_word_t apply_command(input cmd_word_t w);
    result_word_t r;
    logic [ogbe_pkg::WORD_W-1:0] take;
    logic [ogbe_pkg::WORD_W-1:0] child;
    logic [ogbe_pkg::SCORE_W-1:0] cs;
    int n;
    int lim;
    int top;
    int i;
    r = '0;
    n = (reg_pop > 7'd64) ? 64 : int'(reg_pop);
    case (w.cmd)
      ogbe_pkg::CMD_LOAD: begin
        store_genes[w.target_index] = w.gene_bits;
        store_score[w.target_index] = ogbe_pkg::SCORE_W'($countones(w.gene_bits));
        r.status = ogbe_pkg::ST_LOADED;
      end
      ogbe_pkg::CMD_BREED: begin
        if ({1'b0, w.chance} >= reg_xover) begin
          r.status = ogbe_pkg::ST_NO_XOVER;
        end else if (int'(w.target_index) >= n || int'(w.mother_index) >= n ||
                     w.target_index == w.mother_index) begin
          r.status = ogbe_pkg::ST_BAD_PARENT;
        end else begin
          take = ALL_ONES >> (ogbe_pkg::WORD_W - 1 - int'(w.cut_point));
          child = (store_genes[w.target_index] & take) |
                  (store_genes[w.mother_index] & ~take);
          if ({1'b0, w.chance} < reg_mut) child[w.flip_position] = ~child[w.flip_position];
          cs = ogbe_pkg::SCORE_W'($countones(child));
          if (cs > store_score[w.target_index]) begin
            store_genes[w.target_index] = child;
            store_score[w.target_index] = cs;
            r.status = ogbe_pkg::ST_REPLACED;
          end else begin
            r.status = ogbe_pkg::ST_NOT_BETTER;
          end
          r.child_genes = child;
          r.child_score = cs;
        end
      end
      ogbe_pkg::CMD_BEST: begin
        lim = (n < 1) ? 1 : n;
        top = 0;
        for (i = 1; i < lim; i++) begin
          if (store_score[i] > store_score[top]) top = i;
        end
        r.status = ogbe_pkg::ST_BEST;
        r.best_index = ogbe_pkg::IDX_W'(top);
        r.best_score = store_score[top];
        r.best_genes = store_genes[top];
        r.optimum_found = (store_score[top] == ogbe_pkg::SCORE_W'(ogbe_pkg::GENES_DEF));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_word_t random_command();
    cmd_word_t w;
    logic [ogbe_pkg::WORD_W-1:0] a;
    logic [ogbe_pkg::WORD_W-1:0] b;
    int n;
    int pick;
    int near;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    n = (reg_pop > 7'd64) ? 64 : int'(reg_pop);
    w = cmd_of(ogbe_pkg::CMD_BREED, $urandom_range(63), $urandom_range(63),
               {$urandom, $urandom}, $urandom_range(65535), $urandom_range(63),
               $urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 22) begin
      w.cmd = ogbe_pkg::CMD_LOAD;
      case ($urandom_range(7))
        0: w.gene_bits = a & b & w.gene_bits;
        1: w.gene_bits = a | b | w.gene_bits;
        2: w.gene_bits = ALL_ONES;
        3: w.gene_bits = ALL_ONES ^ (64'd1 << $urandom_range(63));
        default: ;
      endcase
    end else if (pick < 82) begin
      if (n >= 2 && $urandom_range(9) < 8) begin
        w.target_index = ogbe_pkg::IDX_W'($urandom_range(n - 1));
        w.mother_index = ogbe_pkg::IDX_W'((int'(w.target_index) + 1 +
                                           $urandom_range(n - 2)) % n);
      end
      if ($urandom_range(3) == 0) begin
        near = int'($urandom_range(1) ? reg_xover : reg_mut) - int'($urandom_range(1));
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        w.chance = 16'(near);
      end
    end else if (pick < 96) begin
      w.cmd = ogbe_pkg::CMD_BEST;
    end else begin
      w.cmd = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic add_row(input cmd_word_t w, input logic typed, input result_word_t want);
    dir_row_t row;
    row.w = w;
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic send_command(input cmd_word_t w, input logic typed, input result_word_t want);
    result_word_t predicted;
    logic fire;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= w.cmd;
    target_index_i  <= w.target_index;
    mother_index_i  <= w.mother_index;
    gene_bits_i     <= w.gene_bits;
    chance_i        <= w.chance;
    cut_point_i     <= w.cut_point;
    flip_position_i <= w.flip_position;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk_i);
      fire = !in_stall_o;
      @(posedge clk_i);
    end
    predicted = apply_command(w);
    if (w.cmd != CMD_UNUSED) begin
      pending_results.insert(pending_results.size(), typed ? want : predicted);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_registers(input int unsigned pop, input int unsigned xo,
                               input int unsigned mut);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ogbe_pkg::CFG_POP_IN_USE;
    cfg_data_i <= ogbe_pkg::CFG_W'(pop);
    @(posedge clk_i);
    cfg_idx_i  <= ogbe_pkg::CFG_XOVER_THR;
    cfg_data_i <= ogbe_pkg::CFG_W'(xo);
    @(posedge clk_i);
    cfg_idx_i  <= ogbe_pkg::CFG_MUT_THR;
    cfg_data_i <= ogbe_pkg::CFG_W'(mut);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_pop   = 7'(pop);
    reg_xover = ogbe_pkg::THR_W'(xo);
    reg_mut   = ogbe_pkg::THR_W'(mut);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always begin
    @(negedge clk_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_seen = result_of(status_o, child_genes_o, child_score_o, best_index_o,
                           best_score_o, best_genes_o, optimum_found_o);
      @(posedge clk_i);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word, status %0d", out_seen.status);
      end else if (out_seen.status !== pending_results[0].status ||
                   out_seen.child_genes !== pending_results[0].child_genes ||
                   out_seen.child_score !== pending_results[0].child_score ||
                   out_seen.best_index !== pending_results[0].best_index ||
                   out_seen.best_score !== pending_results[0].best_score ||
                   out_seen.best_genes !== pending_results[0].best_genes ||
                   out_seen.optimum_found !== pending_results[0].optimum_found) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch exp st=%0d cg=%h cs=%0d bi=%0d bs=%0d bg=%h opt=%0d",
                   pending_results[0].status, pending_results[0].child_genes,
                   pending_results[0].child_score, pending_results[0].best_index,
                   pending_results[0].best_score, pending_results[0].best_genes,
                   pending_results[0].optimum_found);
          $display("         got st=%0d cg=%h cs=%0d bi=%0d bs=%0d bg=%h opt=%0d",
                   out_seen.status, out_seen.child_genes, out_seen.child_score,
                   out_seen.best_index, out_seen.best_score, out_seen.best_genes,
                   out_seen.optimum_found);
        end
      end
      if (pending_results.size() != 0) void'(pending_results.pop_front());
    end
  end

  initial begin : stimulus
    int i;
    int phase;
    int k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry gets written before anything reads the store
    for (i = 0; i < 64; i++) begin
      send_command(cmd_of(ogbe_pkg::CMD_LOAD, i, 0, {$urandom, $urandom}, 0, 0, 0),
                   1'b0, NO_RESULT);
    end

    add_row(cmd_of(ogbe_pkg::CMD_LOAD, 0, 0, ALL_ONES, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_LOADED, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_LOAD, 1, 0, '0, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_LOADED, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_LOAD, 2, 0, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_LOADED, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_LOAD, 63, 63, 64'h8000_0000_0000_0001, 65535, 63, 63), 1'b1,
            result_of(ogbe_pkg::ST_LOADED, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BEST, 0, 0, '0, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_BEST, '0, 0, 0, 64, ALL_ONES, 1'b1));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 0, 1, '0, 65535, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_NO_XOVER, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 0, 1, '0, 45875, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_NO_XOVER, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 3, 3, '0, 45874, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_BAD_PARENT, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 50, 0, '0, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_BAD_PARENT, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 0, 63, '0, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_BAD_PARENT, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 1, 0, '0, 13107, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_REPLACED, 64'hFFFF_FFFF_FFFF_FFFE, 63, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 1, 0, '0, 0, 63, 0), 1'b1,
            result_of(ogbe_pkg::ST_REPLACED, ALL_ONES, 64, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 0, 1, '0, 13106, 5, 40), 1'b0, NO_RESULT);
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 2, 49, '0, 100, 31, 63), 1'b0, NO_RESULT);
    add_row(cmd_of(ogbe_pkg::CMD_BEST, 0, 0, '0, 0, 0, 0), 1'b0, NO_RESULT);
    add_row(cmd_of(ogbe_pkg::CMD_LOAD, 0, 0, '0, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_LOADED, '0, 0, 0, 0, '0, 1'b0));
    add_row(cmd_of(ogbe_pkg::CMD_BEST, 0, 0, '0, 0, 0, 0), 1'b0, NO_RESULT);
    add_row(cmd_of(CMD_UNUSED, 5, 6, 64'h5555_5555_5555_5555, 7, 8, 9), 1'b0, NO_RESULT);
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 49, 48, '0, 45874, 62, 33), 1'b0, NO_RESULT);
    add_row(cmd_of(ogbe_pkg::CMD_BREED, 48, 49, '0, 13106, 1, 62), 1'b0, NO_RESULT);
    add_row(cmd_of(ogbe_pkg::CMD_LOAD, 5, 0, 64'h0123_4567_89AB_CDEF, 0, 0, 0), 1'b1,
            result_of(ogbe_pkg::ST_LOADED, '0, 0, 0, 0, '0, 1'b0));

    for (i = 0; i < directed_rows.size(); i++) begin
      send_command(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
    end

    set_pop[6]   = $urandom_range(64, 2);
    set_xover[6] = $urandom_range(65536);
    set_mut[6]   = $urandom_range(65536);
    set_pop[7]   = $urandom_range(64, 2);
    set_xover[7] = $urandom_range(65536);
    set_mut[7]   = $urandom_range(65536);

    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      set_registers(set_pop[phase], set_xover[phase], set_mut[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (k == 100) drain_results();
        send_command(random_command(), 1'b0, NO_RESULT);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("onemax_genetic_breeding_engine regression: pass");
    end else begin
      $display("onemax_genetic_breeding_engine regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("onemax_genetic_breeding_engine regression: fail");
    $finish;
  end

endmodule
